/* rtl/cdq_pkg.sv */
package cdq_pkg;

  // Fixed field widths of the ports
  localparam int REQ_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 4;
  localparam int CAP_W     = 5;
  localparam int COUNT_W   = 5;
  localparam int STAT_W    = 2;

  // Build defaults and capacity after reset
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_RD_FRONT   = 3'd4,
    REQ_RD_BACK    = 3'd5,
    REQ_RD_INDEX   = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast controls for the row of cells
  typedef struct packed {
    logic shift_in;   // push front: every cell takes its lower neighbor
    logic shift_out;  // pop front: every cell takes its upper neighbor
    logic wr_back;    // push back: the addressed cell takes the pushed word
    logic rd_en;      // the addressed cell drives the read chain
  } cell_ctl_t;

endpackage

/* rtl/circular_deque_top.sv */
// channel   direction  handshake             fields
// request   in         start, busy           req_type, push_value, position
// result    out        done (one cycle)      read_value, count, is_empty, is_full, status
// config    in         cfg_we                cfg_wdata (capacity in use)
//
// One request per cycle: a request accepted at one edge has its result word on the
// result ports, with done high, for the next cycle. The elements sit in a row of
// DEPTH cells in front-to-back order; push and pop at the front shift the whole row
// at once, and a read walks the OR chain through the row.
// Reset is synchronous; busy is high while rst is high. done cannot be stalled.
module circular_deque_top #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cdq_pkg::REQ_W-1:0]     req_type,
  input  logic [cdq_pkg::VALUE_W-1:0]   push_value,
  input  logic [cdq_pkg::POS_W-1:0]     position,
  input  logic                          cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]     cfg_wdata,
  output logic                          done,
  output logic [cdq_pkg::VALUE_W-1:0]   read_value,
  output logic [cdq_pkg::COUNT_W-1:0]   count,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [cdq_pkg::STAT_W-1:0]    status
);
  import cdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cell_ctl_t             ctl;
  logic [IW-1:0]         idx;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] chain  [DEPTH+1];

  assign wr_data  = DATA_WIDTH'(push_value);
  assign chain[0] = '0;

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .position   (position),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .chain_data (chain[DEPTH]),
    .ctl        (ctl),
    .idx        (idx),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .status     (status)
  );

  // Build the row; the front cell takes the pushed word, the last sees zero above
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = wr_data;
    end else begin : g_mid
      assign lower = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner
      assign upper = cell_q[i+1];
    end

    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (idx),
      .wr_data    (wr_data),
      .lower_data (lower),
      .upper_data (upper),
      .rd_in      (chain[i]),
      .data       (cell_q[i]),
      .rd_out     (chain[i+1])
    );
  end

endmodule

/* rtl/cdq_cell.sv */
module cdq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cdq_pkg::cell_ctl_t    ctl,
  input  logic [IW-1:0]         idx,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] lower_data,
  input  logic [DATA_WIDTH-1:0] upper_data,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_out
);
  import cdq_pkg::*;

  logic hit;

  assign hit = (idx == IW'(INDEX));

  // Shift along the row, or take the pushed word at the back slot; otherwise hold
  always_ff @(posedge clk) begin
    priority if (ctl.shift_in) begin
      data <= lower_data;
    end else if (ctl.shift_out) begin
      data <= upper_data;
    end else if (ctl.wr_back && hit) begin
      data <= wr_data;
    end else begin
      data <= data;
    end
  end

  // Merge this cell's word onto the read chain when addressed
  assign rd_out = rd_in | ((ctl.rd_en && hit) ? data : '0);

endmodule

/* rtl/cdq_ctrl.sv */
module cdq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cdq_pkg::REQ_W-1:0]     req_type,
  input  logic [cdq_pkg::POS_W-1:0]     position,
  input  logic                          cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic [DATA_WIDTH-1:0]         chain_data,
  output cdq_pkg::cell_ctl_t            ctl,
  output logic [IW-1:0]                 idx,
  output logic                          busy,
  output logic                          done,
  output logic [cdq_pkg::VALUE_W-1:0]   read_value,
  output logic [cdq_pkg::COUNT_W-1:0]   count,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [cdq_pkg::STAT_W-1:0]    status
);
  import cdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] cap;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cnt_next;
  logic [CW-1:0]    cap_eff;
  logic             acc;
  logic             full_now;
  logic             empty_now;
  status_t          st;
  cell_ctl_t        ctl_raw;

  assign busy      = rst;
  assign acc       = start && !busy;
  assign full_now  = (cnt >= cap_eff);
  assign empty_now = (cnt == '0);

  // Clamp the capacity in use to 1..DEPTH
  always_comb begin
    if (cap == '0) begin
      cap_eff = CW'(1);
    end else if (int'(cap) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap);
    end
  end

  // Decode the request: status, new count, cell controls
  always_comb begin
    st       = ST_OK;
    cnt_next = cnt;
    ctl_raw  = '0;
    idx      = '0;
    unique case (req_t'(req_type))
      REQ_PUSH_BACK: begin
        idx = IW'(cnt);
        if (full_now) begin
          st = ST_FULL;
        end else begin
          ctl_raw.wr_back = 1'b1;
          cnt_next        = cnt + CW'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (full_now) begin
          st = ST_FULL;
        end else begin
          ctl_raw.shift_in = 1'b1;
          cnt_next         = cnt + CW'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty_now) begin
          st = ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty_now) begin
          st = ST_EMPTY;
        end else begin
          ctl_raw.shift_out = 1'b1;
          cnt_next          = cnt - CW'(1);
        end
      end
      REQ_RD_FRONT: begin
        if (empty_now) begin
          st = ST_EMPTY;
        end else begin
          ctl_raw.rd_en = 1'b1;
        end
      end
      REQ_RD_BACK: begin
        idx = IW'(cnt - CW'(1));
        if (empty_now) begin
          st = ST_EMPTY;
        end else begin
          ctl_raw.rd_en = 1'b1;
        end
      end
      REQ_RD_INDEX: begin
        idx = IW'(position);
        if (empty_now) begin
          st = ST_EMPTY;
        end else if (int'(position) >= int'(cnt)) begin
          st = ST_RANGE;
        end else begin
          ctl_raw.rd_en = 1'b1;
        end
      end
      REQ_CLEAR: begin
        cnt_next = '0;
      end
    endcase
  end

  // Cells move only on an accepted request
  assign ctl = acc ? ctl_raw : '0;

  // Capacity and count; a capacity write empties the deque
  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= CAP_RESET;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= acc;
      if (cfg_we) begin
        cap <= cfg_wdata;
        cnt <= '0;
      end else if (acc) begin
        cnt <= cnt_next;
      end
    end
  end

  // Hold the result word for its strobe cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      read_value <= ctl_raw.rd_en ? VALUE_W'(chain_data) : '0;
      count      <= COUNT_W'(cnt_next);
      is_empty   <= (cnt_next == '0);
      is_full    <= (cnt_next == cap_eff);
      status     <= st;
    end
  end

endmodule

/* rtl/cdq_checker.sv */
module cdq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [cdq_pkg::VALUE_W-1:0]   read_value,
  input logic [cdq_pkg::COUNT_W-1:0]   count,
  input logic                          is_empty,
  input logic                          is_full,
  input logic [cdq_pkg::STAT_W-1:0]    status
);
  import cdq_pkg::*;

  // Every accepted request gives a result word in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("result word missing after accepted request");

  // No result word without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result word without a request");

  // Empty flag agrees with the count and never coexists with full
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> ((is_empty == (count == '0)) && !(is_empty && is_full)))
    else $error("empty or full flag inconsistent with count");

  // A rejected push leaves the deque full
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> is_full)
    else $error("push rejected while not full");

  // A failed request reads zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_value == '0))
    else $error("nonzero read value on failed request");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (.*);
